/* sv/gdd_pkg.sv */
// ----------------------------------------------------------------------------
// gdd_pkg - shared definitions for the Gregorian date difference unit
// This package holds the calendar tables, the result order codes, the
// reciprocal constant used for division by 100, and the pipeline enable struct.
// ----------------------------------------------------------------------------
package gdd_pkg;

   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned DNUM_W  = 22;
   localparam int unsigned ORDER_W = 2;

   localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;

   // floor(x / 100) equals (x * 5243) >> 19 for every 14-bit x.
   localparam int unsigned       RECIP_W     = 13;
   localparam logic [RECIP_W-1:0] RECIP_100  = 13'd5243;
   localparam int unsigned       RECIP_SHIFT = 19;
   localparam int unsigned       QUOT_W      = 8;

   localparam logic signed [ORDER_W-1:0] ORDER_EQUAL   = 2'sb00;
   localparam logic signed [ORDER_W-1:0] ORDER_LATER   = 2'sb01;
   localparam logic signed [ORDER_W-1:0] ORDER_EARLIER = 2'sb11;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // One load enable for each register stage inside a day-number pipe.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } stage_en_type;

   // Days in the whole months before the given month of a common year.
   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [8:0] n;
      case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

   // Length of the given month in a common year; zero for a month code that is not a month.
   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] n;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
         4'd2:                                       n = 5'd28;
         default:                                    n = 5'd0;
      endcase
      return n;
   endfunction

endpackage

/* sv/gregorian_date_difference_unit.sv */
// ----------------------------------------------------------------------------
// gregorian_date_difference_unit - days between two Gregorian dates
// Takes a pair of dates per beat and returns their order, the absolute
// number of days between them and a flag for both dates being valid.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Width   Contents
//   req_*     in          48      first_day, first_month, first_year,
//                                 second_day, second_month, second_year
//   rsp_*     out         32      order, day_distance, dates_valid
//
// The unit takes one beat per cycle unless rsp_tready holds it back. It has four
// register stages: the reciprocal multiplies for division by 100, the year-times-365
// multiply with leap checks, the day-number sum, and the final absolute difference
// into the output register.
// Reset (synchronous, active high) empties the pipeline; payload is not reset.
// When rsp_tready is low the stages fill up one by one and req_tready drops
// only once every stage holds a beat, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module gregorian_date_difference_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [4:0] first_day, [8:5] first_month, [22:9] first_year, [27:23] second_day,
   // [31:28] second_month, [45:32] second_year, [47:46] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] order (signed), [23:2] day_distance, [24] dates_valid, [31:25] zero
   output logic [31:0] rsp_tdata
);

   // Unpack the request beat.
   logic [gdd_pkg::DAY_W-1:0]   first_day, second_day;
   logic [gdd_pkg::MONTH_W-1:0] first_month, second_month;
   logic [gdd_pkg::YEAR_W-1:0]  first_year, second_year;

   assign first_day    = req_tdata[4:0];
   assign first_month  = req_tdata[8:5];
   assign first_year   = req_tdata[22:9];
   assign second_day   = req_tdata[27:23];
   assign second_month = req_tdata[31:28];
   assign second_year  = req_tdata[45:32];

   // Pipeline control. A stage loads when it is empty or when the stage after it
   // is loading too; the output register loads when empty or when the result is taken.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;
   gdd_pkg::stage_en_type en;

   assign en4 = !v4_ff || rsp_tready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign en  = '{s1: en1, s2: en2, s3: en3};

   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // The order compares year, then month, then day as plain numbers, valid or not.
   // Concatenating the fields in that order turns it into a single unsigned compare.
   logic [22:0] first_key, second_key;
   logic signed [gdd_pkg::ORDER_W-1:0] ord_in, ord1_ff, ord2_ff, ord3_ff;

   always_comb begin
      first_key  = {first_year, first_month, first_day};
      second_key = {second_year, second_month, second_day};
      if (first_key > second_key) begin
         ord_in = gdd_pkg::ORDER_LATER;
      end else if (first_key < second_key) begin
         ord_in = gdd_pkg::ORDER_EARLIER;
      end else begin
         ord_in = gdd_pkg::ORDER_EQUAL;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) ord1_ff <= ord_in;
      if (en2) ord2_ff <= ord1_ff;
      if (en3) ord3_ff <= ord2_ff;
   end

   // One day-number pipe for each date; both advance in lockstep.
   logic [gdd_pkg::DNUM_W-1:0] n1, n2;
   logic                       ok1, ok2;

   gdd_day_number u_first (
      .clock      (clock),
      .en         (en),
      .day        (first_day),
      .month      (first_month),
      .year       (first_year),
      .day_number (n1),
      .date_ok    (ok1)
   );

   gdd_day_number u_second (
      .clock      (clock),
      .en         (en),
      .day        (second_day),
      .month      (second_month),
      .year       (second_year),
      .day_number (n2),
      .date_ok    (ok2)
   );

   // Output stage: absolute difference, forced to zero when either date is invalid.
   logic                               both_ok;
   logic [gdd_pkg::DNUM_W-1:0]         dist_in, dist_ff;
   logic signed [gdd_pkg::ORDER_W-1:0] ord4_ff;
   logic                               valid_ff;

   always_comb begin
      both_ok = ok1 && ok2;
      if (!both_ok) begin
         dist_in = '0;
      end else if (n1 >= n2) begin
         dist_in = n1 - n2;
      end else begin
         dist_in = n2 - n1;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         dist_ff  <= dist_in;
         ord4_ff  <= ord3_ff;
         valid_ff <= both_ok;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {7'b0, valid_ff, dist_ff, ord4_ff};

endmodule

/* sv/gdd_day_number.sv */
// ----------------------------------------------------------------------------
// gdd_day_number - three-stage day-number pipe for one date
// Turns day, month and year into a serial day number (0001-01-01 is day 1)
// and checks that the date is a valid Gregorian calendar date.
// ----------------------------------------------------------------------------
module gdd_day_number (
   input  logic                          clock,
   input  gdd_pkg::stage_en_type         en,
   input  logic [gdd_pkg::DAY_W-1:0]     day,
   input  logic [gdd_pkg::MONTH_W-1:0]   month,
   input  logic [gdd_pkg::YEAR_W-1:0]    year,
   output logic [gdd_pkg::DNUM_W-1:0]    day_number,
   output logic                          date_ok
);

   localparam int unsigned PROD_W = gdd_pkg::YEAR_W + gdd_pkg::RECIP_W;

   // Stage 1: prior-year count and the two divisions by 100.
   logic [gdd_pkg::YEAR_W-1:0]  p_in, p_ff, y_ff;
   logic [gdd_pkg::MONTH_W-1:0] m_ff;
   logic [gdd_pkg::DAY_W-1:0]   d_ff;
   logic [PROD_W-1:0]           prod_p, prod_y;
   logic [gdd_pkg::QUOT_W-1:0]  q100p_in, q100p_ff, q100y_in, q100y_ff;

   always_comb begin
      p_in     = year - 14'd1;
      prod_p   = PROD_W'(p_in) * PROD_W'(gdd_pkg::RECIP_100);
      prod_y   = PROD_W'(year) * PROD_W'(gdd_pkg::RECIP_100);
      q100p_in = prod_p[gdd_pkg::RECIP_SHIFT +: gdd_pkg::QUOT_W];
      q100y_in = prod_y[gdd_pkg::RECIP_SHIFT +: gdd_pkg::QUOT_W];
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         p_ff     <= p_in;
         y_ff     <= year;
         m_ff     <= month;
         d_ff     <= day;
         q100p_ff <= q100p_in;
         q100y_ff <= q100y_in;
      end
   end

   // Stage 2: leap year, validity, whole-year days and the in-year offset.
   logic [14:0]                hundreds;
   logic                       is_century, leap;
   logic [gdd_pkg::DAY_W-1:0]  len;
   logic                       ok_in, ok2_ff, ok3_ff;
   logic [22:0]                yd_full;
   logic [gdd_pkg::DNUM_W-1:0] yd_in, yd_ff;
   logic [11:0]                cor_in, cor_ff;
   logic [8:0]                 md_in, md_ff;

   always_comb begin
      hundreds   = 15'(q100y_ff) * 15'd100;
      is_century = (hundreds == {1'b0, y_ff});
      leap       = (y_ff[1:0] == 2'b00) && (!is_century || (q100y_ff[1:0] == 2'b00));
      len        = gdd_pkg::month_length(m_ff);
      if (m_ff == gdd_pkg::MONTH_FEB && leap) begin
         len = len + 5'd1;
      end
      ok_in = (y_ff != '0) && (y_ff <= gdd_pkg::MAX_YEAR)
              && (m_ff >= gdd_pkg::MONTH_JAN) && (m_ff <= gdd_pkg::MONTH_DEC)
              && (d_ff != '0) && (d_ff <= len);
      yd_full = 23'(p_ff) * 23'd365;
      yd_in   = yd_full[gdd_pkg::DNUM_W-1:0];
      // p/4 - p/100 + p/400, where p/400 is (p/100)/4.
      cor_in  = p_ff[13:2] - 12'(q100p_ff) + 12'(q100p_ff[7:2]);
      md_in   = gdd_pkg::days_before_month(m_ff) + 9'(d_ff)
                + 9'((m_ff > gdd_pkg::MONTH_FEB) && leap);
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         yd_ff  <= yd_in;
         cor_ff <= cor_in;
         md_ff  <= md_in;
         ok2_ff <= ok_in;
      end
   end

   // Stage 3: final sum.
   logic [gdd_pkg::DNUM_W-1:0] n_ff;

   always_ff @(posedge clock) begin
      if (en.s3) begin
         n_ff   <= yd_ff + gdd_pkg::DNUM_W'(cor_ff) + gdd_pkg::DNUM_W'(md_ff);
         ok3_ff <= ok2_ff;
      end
   end

   assign day_number = n_ff;
   assign date_ok    = ok3_ff;

endmodule

/* bench/tb_gregorian_date_difference_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gregorian_date_difference_unit - bench for the date difference unit
// Drives date pairs over the request stream with random gaps, holds the
// response stream back at random, and checks each response beat against a
// calendar model of its own: a short table of edge cases first, then about
// two thousand random pairs, mostly valid dates with some broken and raw ones.
// ----------------------------------------------------------------------------
module tb_gregorian_date_difference_unit;

   localparam int unsigned RANDOM_PAIRS = 1950;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [gdd_pkg::YEAR_W-1:0]  y;
      logic [gdd_pkg::MONTH_W-1:0] m;
      logic [gdd_pkg::DAY_W-1:0]   d;
   } cal_date_type;

   // The first date sits in the low bits, as on req_tdata.
   typedef struct packed {
      cal_date_type second;
      cal_date_type first;
   } date_pair_type;

   // Same layout as rsp_tdata[24:0].
   typedef struct packed {
      logic                               valid;
      logic [gdd_pkg::DNUM_W-1:0]         distance;
      logic signed [gdd_pkg::ORDER_W-1:0] order;
   } span_type;

   typedef struct packed {
      logic [gdd_pkg::DAY_W-1:0]          d1;
      logic [gdd_pkg::MONTH_W-1:0]        m1;
      logic [gdd_pkg::YEAR_W-1:0]         y1;
      logic [gdd_pkg::DAY_W-1:0]          d2;
      logic [gdd_pkg::MONTH_W-1:0]        m2;
      logic [gdd_pkg::YEAR_W-1:0]         y2;
      logic                               fixed;
      logic signed [gdd_pkg::ORDER_W-1:0] order;
      logic [gdd_pkg::DNUM_W-1:0]         distance;
      logic                               valid;
   } edge_row_type;

   localparam int unsigned EDGE_ROWS = 23;

   // Rows with fixed set carry the expected response; the rest go through the
   // calendar model.
   localparam edge_row_type EDGE_CASES [EDGE_ROWS] = '{
      '{1, 1, 1, 1, 1, 1, 1, gdd_pkg::ORDER_EQUAL, 0, 1},
      '{31, 12, 9999, 1, 1, 1, 1, gdd_pkg::ORDER_LATER, 3652058, 1},
      '{1, 1, 1, 31, 12, 9999, 1, gdd_pkg::ORDER_EARLIER, 3652058, 1},
      '{31, 12, 9999, 31, 12, 9999, 1, gdd_pkg::ORDER_EQUAL, 0, 1},
      '{1, 1, 0, 1, 1, 1, 1, gdd_pkg::ORDER_EARLIER, 0, 0},
      '{0, 0, 0, 0, 0, 0, 1, gdd_pkg::ORDER_EQUAL, 0, 0},
      '{1, 0, 2024, 1, 1, 2024, 1, gdd_pkg::ORDER_EARLIER, 0, 0},
      '{1, 13, 2024, 1, 12, 2024, 1, gdd_pkg::ORDER_LATER, 0, 0},
      '{31, 15, 16383, 31, 15, 16383, 1, gdd_pkg::ORDER_EQUAL, 0, 0},
      '{0, 1, 2024, 1, 1, 2024, 1, gdd_pkg::ORDER_EARLIER, 0, 0},
      '{31, 4, 2023, 1, 5, 2023, 1, gdd_pkg::ORDER_EARLIER, 0, 0},
      '{29, 2, 1900, 1, 3, 1900, 1, gdd_pkg::ORDER_EARLIER, 0, 0},
      '{29, 2, 2023, 28, 2, 2023, 1, gdd_pkg::ORDER_LATER, 0, 0},
      '{1, 1, 10000, 1, 1, 9999, 1, gdd_pkg::ORDER_LATER, 0, 0},
      '{1, 1, 9999, 1, 1, 16383, 1, gdd_pkg::ORDER_EARLIER, 0, 0},
      '{29, 2, 2000, 1, 3, 2000, 0, gdd_pkg::ORDER_EQUAL, 0, 0},
      '{29, 2, 2004, 28, 2, 2004, 0, gdd_pkg::ORDER_EQUAL, 0, 0},
      '{28, 2, 1900, 1, 3, 1900, 0, gdd_pkg::ORDER_EQUAL, 0, 0},
      '{28, 2, 2000, 1, 3, 2000, 0, gdd_pkg::ORDER_EQUAL, 0, 0},
      '{31, 12, 1999, 1, 1, 2000, 0, gdd_pkg::ORDER_EQUAL, 0, 0},
      '{1, 3, 2000, 1, 3, 1600, 0, gdd_pkg::ORDER_EQUAL, 0, 0},
      '{15, 6, 2024, 15, 6, 2024, 0, gdd_pkg::ORDER_EQUAL, 0, 0},
      '{1, 2, 2024, 31, 1, 2024, 0, gdd_pkg::ORDER_EQUAL, 0, 0}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   span_type    expected_spans [$];
   int unsigned mismatches;
   bit          calm;

   gregorian_date_difference_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // ---------------------------------------------------------------- calendar

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned month_len(input int unsigned m, input int unsigned y);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap_year(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic int unsigned days_ahead_of_month(input int unsigned m);
      case (m)
         2:       return 31;
         3:       return 59;
         4:       return 90;
         5:       return 120;
         6:       return 151;
         7:       return 181;
         8:       return 212;
         9:       return 243;
         10:      return 273;
         11:      return 304;
         12:      return 334;
         default: return 0;
      endcase
   endfunction

   function automatic bit date_ok(input cal_date_type c);
      if (c.y < 1 || c.y > 9999) return 1'b0;
      if (c.m < 1 || c.m > 12) return 1'b0;
      return (c.d >= 1) && (c.d <= month_len(c.m, c.y));
   endfunction

   // Serial day count; the first of January of year 1 is day 1.
   function automatic int unsigned day_serial(input cal_date_type c);
      int unsigned p;
      int unsigned n;
      p = c.y - 1;
      n = p * 365 + p / 4 - p / 100 + p / 400 + days_ahead_of_month(c.m) + c.d;
      if (c.m > 2 && leap_year(c.y)) n = n + 1;
      return n;
   endfunction

   function automatic span_type predict_span(input date_pair_type p);
      span_type    s;
      int unsigned n1;
      int unsigned n2;
      // Order compares the raw fields, whether the dates are valid or not.
      if (p.first.y != p.second.y)
         s.order = (p.first.y > p.second.y) ? gdd_pkg::ORDER_LATER : gdd_pkg::ORDER_EARLIER;
      else if (p.first.m != p.second.m)
         s.order = (p.first.m > p.second.m) ? gdd_pkg::ORDER_LATER : gdd_pkg::ORDER_EARLIER;
      else if (p.first.d != p.second.d)
         s.order = (p.first.d > p.second.d) ? gdd_pkg::ORDER_LATER : gdd_pkg::ORDER_EARLIER;
      else
         s.order = gdd_pkg::ORDER_EQUAL;
      s.valid    = date_ok(p.first) && date_ok(p.second);
      s.distance = '0;
      if (s.valid) begin
         n1 = day_serial(p.first);
         n2 = day_serial(p.second);
         s.distance = (n1 >= n2) ? gdd_pkg::DNUM_W'(n1 - n2) : gdd_pkg::DNUM_W'(n2 - n1);
      end
      return s;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic cal_date_type random_date();
      cal_date_type c;
      int unsigned  pick;
      pick = $urandom_range(0, 9);
      if (pick < 2)
         c.y = gdd_pkg::YEAR_W'(100 * $urandom_range(1, 99));
      else if (pick == 2)
         c.y = gdd_pkg::YEAR_W'($urandom_range(1, 10));
      else if (pick == 3)
         c.y = gdd_pkg::YEAR_W'($urandom_range(9990, 9999));
      else
         c.y = gdd_pkg::YEAR_W'($urandom_range(1, 9999));
      c.m = gdd_pkg::MONTH_W'($urandom_range(1, 12));
      c.d = gdd_pkg::DAY_W'($urandom_range(1, month_len(c.m, c.y)));
      return c;
   endfunction

   // Spoils a valid date in one of the ways the unit must flag.
   function automatic cal_date_type break_date(input cal_date_type c);
      int unsigned y;
      case ($urandom_range(0, 5))
         0: c.d = '0;
         1: begin
            if (month_len(c.m, c.y) < 31)
               c.d = gdd_pkg::DAY_W'(month_len(c.m, c.y) + 1);
            else
               c.m = gdd_pkg::MONTH_W'($urandom_range(13, 15));
         end
         2: c.m = '0;
         3: c.y = '0;
         4: c.y = gdd_pkg::YEAR_W'($urandom_range(10000, 16383));
         default: begin
            y = $urandom_range(1, 9999);
            while (leap_year(y)) y = y + 1;
            c.y = gdd_pkg::YEAR_W'(y);
            c.m = gdd_pkg::MONTH_FEB;
            c.d = gdd_pkg::DAY_W'(29);
         end
      endcase
      return c;
   endfunction

   function automatic date_pair_type random_pair();
      date_pair_type p;
      int unsigned   shape;
      int            ny;
      logic [63:0]   raw;
      shape    = $urandom_range(0, 99);
      p.first  = random_date();
      p.second = random_date();
      if (shape < 25) begin
         // two unrelated valid dates
      end else if (shape < 45) begin
         ny = int'(p.first.y) + int'($urandom_range(0, 4)) - 2;
         if (ny < 1) ny = 1;
         if (ny > 9999) ny = 9999;
         p.second.y = gdd_pkg::YEAR_W'(ny);
         p.second.d = gdd_pkg::DAY_W'($urandom_range(1, month_len(p.second.m, p.second.y)));
      end else if (shape < 55) begin
         p.second = p.first;
      end else if (shape < 65) begin
         p.second   = p.first;
         p.second.d = gdd_pkg::DAY_W'($urandom_range(1, month_len(p.first.m, p.first.y)));
      end else if (shape < 80) begin
         if ($urandom_range(0, 1) == 0)
            p.first = break_date(p.first);
         else
            p.second = break_date(p.second);
      end else begin
         raw = {$urandom, $urandom};
         p   = raw[45:0];
      end
      return p;
   endfunction

   function automatic int unsigned idle_cycles();
      if (calm || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(1, 10);
   endfunction

   // One request beat; the expected response is queued when the beat is taken.
   task automatic send_pair(input date_pair_type pair, input span_type want, input bit drain);
      int unsigned gap;
      gap = idle_cycles();
      if (drain) begin
         // Hold off until the pipeline has returned everything.
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (expected_spans.size() != 0) @(posedge clock);
      end else if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, pair};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_spans.push_back(want);
   endtask

   initial begin
      date_pair_type pair;
      span_type      want;
      edge_row_type  row;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      mismatches = 0;
      calm       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (reset) @(posedge clock);

      for (int i = 0; i < EDGE_ROWS; i++) begin
         row = EDGE_CASES[i];
         pair.first  = '{y: row.y1, m: row.m1, d: row.d1};
         pair.second = '{y: row.y2, m: row.m2, d: row.d2};
         if (row.fixed)
            want = '{valid: row.valid, distance: row.distance, order: row.order};
         else
            want = predict_span(pair);
         send_pair(pair, want, 1'b0);
      end

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         // Every fourth stretch of 150 beats runs with no random gaps on either side.
         calm = ((i / 150) % 4) == 1;
         pair = random_pair();
         send_pair(pair, predict_span(pair), (i == 700) || (i == 1400));
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;

      while (expected_spans.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Response side: a random stall before each beat is taken.
   initial begin
      int unsigned stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_cycles();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      span_type got;
      span_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[24:0];
         if (expected_spans.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: response beat with nothing outstanding: %h", $realtime, rsp_tdata);
         end else begin
            want = expected_spans.pop_front();
            if (got.order !== want.order || got.distance !== want.distance ||
                got.valid !== want.valid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: order %0d/%0d distance %0d/%0d valid %0b/%0b (want/got)",
                           $realtime, want.order, got.order, want.distance, got.distance,
                           want.valid, got.valid);
            end
         end
      end
   end

   initial begin
      #1_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

/* files.f */
sv/gdd_pkg.sv
sv/gdd_day_number.sv
sv/gregorian_date_difference_unit.sv
bench/tb_gregorian_date_difference_unit.sv
